// ----- design/cluster_cache_controller_macros.svh -----
// assertion macros for the cluster cache controller
`ifndef CLUSTER_CACHE_CONTROLLER_MACROS_SVH
`define CLUSTER_CACHE_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF
`define CCC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cluster cache controller check failed");
`define CCC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cluster cache controller check failed");
`else
`define CCC_ASSERT(lbl, clk, rstn, prop)
`define CCC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- design/ccc_pkg.sv -----
package ccc_pkg;

  localparam int SLOTS_DEF = 4;
  localparam int SPC_DEF   = 8;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int CNT_W  = 4;
  localparam int SLOT_W = 2;
  localparam int MASK_W = 8;
  localparam int SEC_W  = 4;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_BAD   = 2'd3;

  typedef struct packed {
    logic match;
    logic empty;
    logic older;
  } cmp_res_t;

endpackage

// ----- design/ccc_cmp.sv -----
module ccc_cmp (
  input  logic [ccc_pkg::DATA_W-1:0] target,
  input  logic [ccc_pkg::DATA_W-1:0] slot_cluster,
  input  logic [ccc_pkg::DATA_W-1:0] slot_stamp,
  input  logic [ccc_pkg::DATA_W-1:0] best_stamp,
  output ccc_pkg::cmp_res_t          res
);

  assign res.match = (slot_cluster == target);
  assign res.empty = (slot_cluster == '0);
  assign res.older = (slot_stamp < best_stamp);

endmodule

// ----- design/ccc_div.sv -----
module ccc_div #(
  parameter int SECTORS_PER_CLUSTER = ccc_pkg::SPC_DEF,
  localparam int OW = (SECTORS_PER_CLUSTER > 1) ? $clog2(SECTORS_PER_CLUSTER) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [ccc_pkg::DATA_W-1:0] dividend,
  output logic                       done,
  output logic [ccc_pkg::DATA_W-1:0] quotient,
  output logic [OW-1:0]              remainder
);

  localparam bit POW2 = ((SECTORS_PER_CLUSTER & (SECTORS_PER_CLUSTER - 1)) == 0);
  localparam int SH = $clog2(SECTORS_PER_CLUSTER);
  localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / 64'(SECTORS_PER_CLUSTER);
  localparam logic [31:0] RECIP = RECIP_FULL[31:0];
  localparam logic [7:0] SPC8 = 8'(SECTORS_PER_CLUSTER);

  logic [3:0]                  v_r;
  logic [ccc_pkg::DATA_W-1:0]  rel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], go};
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rel_r <= dividend;
    end
  end

  assign done = v_r[3];

  generate
    if (POW2) begin : g_shift
      always_ff @(posedge clk) begin
        if (v_r[2]) begin
          quotient  <= rel_r >> SH;
          remainder <= OW'(rel_r & 32'(SECTORS_PER_CLUSTER - 1));
        end
      end
    end else begin : g_recip
      logic [63:0] prod_r;
      logic [31:0] q0_r;
      logic [7:0]  r0_r;

      // quotient estimate is exact or one short
      always_ff @(posedge clk) begin
        if (v_r[0]) begin
          prod_r <= rel_r * RECIP;
        end
        if (v_r[1]) begin
          q0_r <= prod_r[63:32];
          r0_r <= 8'(rel_r[7:0] - 8'(prod_r[39:32] * SPC8));
        end
        if (v_r[2]) begin
          if (r0_r >= SPC8) begin
            quotient  <= q0_r + 32'd1;
            remainder <= OW'(r0_r - SPC8);
          end else begin
            quotient  <= q0_r;
            remainder <= OW'(r0_r);
          end
        end
      end
    end
  endgenerate

endmodule

// ----- design/cluster_cache_controller.sv -----
// channel   direction  transfer when          payload
// in        input      start && !busy        in_command, in_block_number, in_block_count,
//                                            in_valid_sectors
// out       output     out_valid (one cycle) out_slot ... out_last
// cfg       input      cfg_wr_en             cfg_wr_data (data_area_start)
//
// read/write: a constant divider, then one slot a cycle through the shared compare unit,
// then the update state; a rejected request goes to the reject state from idle, or after
// the divider when the cluster range check fails; flush: one slot a cycle, one result per
// dirty slot, or a single last result when no slot is dirty
// busy stays high until the last result is registered; start is ignored while busy
// rst_n is synchronous and clears all slots, the stamp counter and data_area_start
// the receiver cannot stall: every result is valid for exactly one cycle
`include "cluster_cache_controller_macros.svh"

module cluster_cache_controller #(
  parameter int SLOTS               = ccc_pkg::SLOTS_DEF,
  parameter int SECTORS_PER_CLUSTER = ccc_pkg::SPC_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [ccc_pkg::CMD_W-1:0]  in_command,
  input  logic [ccc_pkg::DATA_W-1:0] in_block_number,
  input  logic [ccc_pkg::CNT_W-1:0]  in_block_count,
  input  logic [ccc_pkg::CNT_W-1:0]  in_valid_sectors,
  output logic                       out_valid,
  output logic [ccc_pkg::SLOT_W-1:0] out_slot,
  output logic                       out_hit,
  output logic [ccc_pkg::MASK_W-1:0] out_fill_mask,
  output logic                       out_writeback,
  output logic [ccc_pkg::DATA_W-1:0] out_victim_cluster,
  output logic [ccc_pkg::SEC_W-1:0]  out_victim_sectors,
  output logic [ccc_pkg::MASK_W-1:0] out_victim_fill_mask,
  output logic                       out_status,
  output logic                       out_last,
  input  logic                       cfg_wr_en,
  input  logic [ccc_pkg::DATA_W-1:0] cfg_wr_data
);

  localparam int SPC = SECTORS_PER_CLUSTER;
  localparam int IW  = $clog2(SLOTS);
  localparam int UW  = $clog2(SPC + 1);
  localparam int EW  = $clog2(SPC + 16);
  localparam int OW  = (SPC > 1) ? $clog2(SPC) : 1;
  localparam int DW  = ccc_pkg::DATA_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [EW-1:0] SPC_E = EW'(SPC);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_UPDATE,
    ST_FLUSH,
    ST_REJECT
  } state_t;

  state_t state_r;

  logic [DW-1:0]               data_start_r;
  logic [ccc_pkg::CMD_W-1:0]   cmd_r;
  logic [ccc_pkg::CNT_W-1:0]   count_r;
  logic [ccc_pkg::CNT_W-1:0]   vsec_r;
  logic [DW-1:0]               cluster_r;
  logic [OW-1:0]               off_r;
  logic [IW-1:0]               idx_r;
  logic                        flushed_r;

  logic                        hit_r;
  logic [IW-1:0]               hit_idx_r;
  logic [SPC-1:0]              hit_valid_r;
  logic [UW-1:0]               hit_used_r;
  logic                        hit_dirty_r;
  logic                        empty_r;
  logic [IW-1:0]               empty_idx_r;
  logic [DW-1:0]               best_stamp_r;
  logic [IW-1:0]               vict_idx_r;
  logic [DW-1:0]               vict_cluster_r;
  logic [UW-1:0]               vict_used_r;
  logic [SPC-1:0]              vict_valid_r;
  logic                        vict_dirty_r;

  logic [DW-1:0]               slot_cluster_r [SLOTS];
  logic [DW-1:0]               slot_stamp_r   [SLOTS];
  logic [SPC-1:0]              slot_valid_r   [SLOTS];
  logic [UW-1:0]               slot_used_r    [SLOTS];
  logic [SLOTS-1:0]            slot_dirty_r;
  logic [DW-1:0]               stamp_cnt_r;

  logic                        out_valid_r;
  logic [ccc_pkg::SLOT_W-1:0]  out_slot_r;
  logic                        out_hit_r;
  logic [ccc_pkg::MASK_W-1:0]  out_fill_r;
  logic                        out_wb_r;
  logic [DW-1:0]               out_vcl_r;
  logic [ccc_pkg::SEC_W-1:0]   out_vsec_r;
  logic [ccc_pkg::MASK_W-1:0]  out_vfill_r;
  logic                        out_status_r;
  logic                        out_last_r;

  logic                        accept;
  logic                        below;
  logic [DW-1:0]               rel;
  logic                        div_go;
  logic                        div_done;
  logic [DW-1:0]               div_quot;
  logic [OW-1:0]               div_rem;
  logic [DW-1:0]               div_cluster;
  logic [EW-1:0]               div_end;
  logic                        div_ok;
  ccc_pkg::cmp_res_t           cmp_res;
  logic                        take_victim;

  logic [IW-1:0]               sel;
  logic [SPC-1:0]              base_valid;
  logic [UW-1:0]               base_used;
  logic [EW-1:0]               req_end;
  logic [SPC-1:0]              req_mask;
  logic [SPC-1:0]              new_valid;
  logic [SPC-1:0]              fill_vec;
  logic [EW-1:0]               used_a;
  logic [EW-1:0]               vsec_sat;
  logic [EW-1:0]               used_b;
  logic [UW-1:0]               new_used;
  logic                        new_dirty;
  logic                        upd_wb;
  logic [SPC-1:0]              vict_mask;
  logic [SPC-1:0]              vict_fill;

  logic                        f_dirty;
  logic [SPC-1:0]              f_mask;
  logic [SPC-1:0]              f_fill;
  logic                        f_above;

  logic                        res_valid;
  logic [ccc_pkg::SLOT_W-1:0]  res_slot;
  logic                        res_hit;
  logic [ccc_pkg::MASK_W-1:0]  res_fill;
  logic                        res_wb;
  logic [DW-1:0]               res_vcl;
  logic [ccc_pkg::SEC_W-1:0]   res_vsec;
  logic [ccc_pkg::MASK_W-1:0]  res_vfill;
  logic                        res_status;
  logic                        res_last;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign {below, rel} = {1'b0, in_block_number} - {1'b0, data_start_r};
  assign div_go = accept && (in_command != ccc_pkg::CMD_FLUSH)
                  && (in_command != ccc_pkg::CMD_BAD) && !below && (in_block_count != '0);

  ccc_div #(
    .SECTORS_PER_CLUSTER(SECTORS_PER_CLUSTER)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (rel),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  assign div_cluster = div_quot + 32'd2;
  assign div_end     = EW'(div_rem) + EW'(count_r);
  assign div_ok      = (div_end <= SPC_E) && (div_cluster != '0);

  ccc_cmp u_cmp (
    .target      (cluster_r),
    .slot_cluster(slot_cluster_r[idx_r]),
    .slot_stamp  (slot_stamp_r[idx_r]),
    .best_stamp  (best_stamp_r),
    .res         (cmp_res)
  );

  assign take_victim = (idx_r == '0) || cmp_res.older;

  always_comb begin
    sel        = hit_r ? hit_idx_r : (empty_r ? empty_idx_r : vict_idx_r);
    base_valid = hit_r ? hit_valid_r : '0;
    base_used  = hit_r ? hit_used_r : '0;
    req_end    = EW'(off_r) + EW'(count_r);
    for (int j = 0; j < SPC; j++) begin
      req_mask[j]  = (EW'(j) >= EW'(off_r)) && (EW'(j) < req_end);
      vict_mask[j] = EW'(j) < EW'(vict_used_r);
      f_mask[j]    = EW'(j) < EW'(slot_used_r[idx_r]);
    end
    new_valid = base_valid | req_mask;
    fill_vec  = (cmd_r == ccc_pkg::CMD_READ) ? (req_mask & ~base_valid) : '0;
    used_a    = (req_end > EW'(base_used)) ? req_end : EW'(base_used);
    vsec_sat  = (8'(vsec_r) > 8'(SPC)) ? SPC_E : EW'(vsec_r);
    used_b    = ((cmd_r == ccc_pkg::CMD_WRITE) && (vsec_sat > used_a)) ? vsec_sat : used_a;
    new_used  = UW'(used_b);
    new_dirty = (hit_r && hit_dirty_r) || (cmd_r == ccc_pkg::CMD_WRITE);
    upd_wb    = !hit_r && !empty_r && vict_dirty_r;
    vict_fill = ~vict_valid_r & vict_mask;

    f_dirty = slot_dirty_r[idx_r];
    f_fill  = ~slot_valid_r[idx_r] & f_mask;
    f_above = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if (IW'(j) > idx_r) begin
        f_above = f_above | slot_dirty_r[j];
      end
    end

    res_valid  = 1'b0;
    res_slot   = '0;
    res_hit    = 1'b0;
    res_fill   = '0;
    res_wb     = 1'b0;
    res_vcl    = '0;
    res_vsec   = '0;
    res_vfill  = '0;
    res_status = 1'b0;
    res_last   = 1'b0;
    case (state_r)
      ST_UPDATE: begin
        res_valid = 1'b1;
        res_slot  = ccc_pkg::SLOT_W'(sel);
        res_hit   = hit_r;
        res_fill  = ccc_pkg::MASK_W'(fill_vec);
        res_wb    = upd_wb;
        if (upd_wb) begin
          res_vcl   = vict_cluster_r;
          res_vsec  = ccc_pkg::SEC_W'(vict_used_r);
          res_vfill = ccc_pkg::MASK_W'(vict_fill);
        end
        res_last  = 1'b1;
      end
      ST_REJECT: begin
        res_valid  = 1'b1;
        res_status = 1'b1;
        res_last   = 1'b1;
      end
      ST_FLUSH: begin
        if (f_dirty) begin
          res_valid = 1'b1;
          res_slot  = ccc_pkg::SLOT_W'(idx_r);
          res_wb    = 1'b1;
          res_vcl   = slot_cluster_r[idx_r];
          res_vsec  = ccc_pkg::SEC_W'(slot_used_r[idx_r]);
          res_vfill = ccc_pkg::MASK_W'(f_fill);
          res_last  = !f_above;
        end else if ((idx_r == LAST_IDX) && !flushed_r) begin
          res_valid = 1'b1;
          res_last  = 1'b1;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      data_start_r <= '0;
      stamp_cnt_r  <= '0;
      slot_dirty_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_cluster_r[i] <= '0;
        slot_stamp_r[i]   <= '0;
        slot_valid_r[i]   <= '0;
        slot_used_r[i]    <= '0;
      end
    end else begin
      out_valid_r <= res_valid;
      if (res_valid) begin
        out_slot_r   <= res_slot;
        out_hit_r    <= res_hit;
        out_fill_r   <= res_fill;
        out_wb_r     <= res_wb;
        out_vcl_r    <= res_vcl;
        out_vsec_r   <= res_vsec;
        out_vfill_r  <= res_vfill;
        out_status_r <= res_status;
        out_last_r   <= res_last;
      end
      if (cfg_wr_en) begin
        data_start_r <= cfg_wr_data;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cmd_r     <= in_command;
            count_r   <= in_block_count;
            vsec_r    <= in_valid_sectors;
            idx_r     <= '0;
            flushed_r <= 1'b0;
            if (in_command == ccc_pkg::CMD_FLUSH) begin
              state_r <= ST_FLUSH;
            end else if (div_go) begin
              state_r <= ST_DIV;
            end else begin
              state_r <= ST_REJECT;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            cluster_r <= div_cluster;
            off_r     <= div_rem;
            hit_r     <= 1'b0;
            empty_r   <= 1'b0;
            state_r   <= div_ok ? ST_SCAN : ST_REJECT;
          end
        end
        ST_SCAN: begin
          if (cmp_res.match && !hit_r) begin
            hit_r       <= 1'b1;
            hit_idx_r   <= idx_r;
            hit_valid_r <= slot_valid_r[idx_r];
            hit_used_r  <= slot_used_r[idx_r];
            hit_dirty_r <= slot_dirty_r[idx_r];
          end
          if (cmp_res.empty && !empty_r) begin
            empty_r     <= 1'b1;
            empty_idx_r <= idx_r;
          end
          if (take_victim) begin
            best_stamp_r   <= slot_stamp_r[idx_r];
            vict_idx_r     <= idx_r;
            vict_cluster_r <= slot_cluster_r[idx_r];
            vict_used_r    <= slot_used_r[idx_r];
            vict_valid_r   <= slot_valid_r[idx_r];
            vict_dirty_r   <= slot_dirty_r[idx_r];
          end
          if (idx_r == LAST_IDX) begin
            state_r <= ST_UPDATE;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        ST_UPDATE: begin
          slot_cluster_r[sel] <= cluster_r;
          slot_stamp_r[sel]   <= stamp_cnt_r;
          slot_valid_r[sel]   <= new_valid;
          slot_used_r[sel]    <= new_used;
          slot_dirty_r[sel]   <= new_dirty;
          stamp_cnt_r         <= stamp_cnt_r + 32'd1;
          state_r             <= ST_IDLE;
        end
        ST_FLUSH: begin
          if (f_dirty) begin
            slot_valid_r[idx_r] <= slot_valid_r[idx_r] | f_mask;
            slot_dirty_r[idx_r] <= 1'b0;
            flushed_r           <= 1'b1;
          end
          if (idx_r == LAST_IDX) begin
            state_r <= ST_IDLE;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        ST_REJECT: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_slot             = out_slot_r;
  assign out_hit              = out_hit_r;
  assign out_fill_mask        = out_fill_r;
  assign out_writeback        = out_wb_r;
  assign out_victim_cluster   = out_vcl_r;
  assign out_victim_sectors   = out_vsec_r;
  assign out_victim_fill_mask = out_vfill_r;
  assign out_status           = out_status_r;
  assign out_last             = out_last_r;

  `CCC_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
  `CCC_ASSERT(a_result_from_work, clk, rst_n, out_valid |-> $past(busy))
  `CCC_ASSERT(a_hit_no_writeback, clk, rst_n, (out_valid && out_hit) |-> !out_writeback)
  `CCC_ASSERT(a_reject_last, clk, rst_n, (out_valid && out_status) |-> (out_last && !out_writeback))
  `CCC_ASSERT(a_flush_clean, clk, rst_n, (state_r == ST_FLUSH && idx_r == LAST_IDX) |=> (slot_dirty_r == '0))

endmodule

// ----- sim/tb_cluster_cache_controller.sv -----
`timescale 1ns / 1ps

module tb_cluster_cache_controller;
  import ccc_pkg::*;

  localparam int NSLOTS = SLOTS_DEF;
  localparam int SPC = SPC_DEF;
  localparam int SETTLE = 16;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [1:0] {
    REQ_ENTRY,
    SET_BASE,
    SET_GAP,
    WAIT_QUIET
  } stim_kind_e;

  typedef struct {
    stim_kind_e  kind;
    logic [1:0]  cmd;
    logic [31:0] blk;
    logic [3:0]  cnt;
    logic [3:0]  vs;
    logic [31:0] value;
  } stim_entry_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic [MASK_W-1:0] fill_mask;
    logic              writeback;
    logic [DATA_W-1:0] victim_cluster;
    logic [SEC_W-1:0]  victim_sectors;
    logic [MASK_W-1:0] victim_fill_mask;
    logic              status;
    logic              last;
  } tag_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] in_command = CMD_READ;
  logic [DATA_W-1:0] in_block_number = '0;
  logic [CNT_W-1:0] in_block_count = '0;
  logic [CNT_W-1:0] in_valid_sectors = '0;
  logic out_valid;
  logic [SLOT_W-1:0] out_slot;
  logic out_hit;
  logic [MASK_W-1:0] out_fill_mask;
  logic out_writeback;
  logic [DATA_W-1:0] out_victim_cluster;
  logic [SEC_W-1:0] out_victim_sectors;
  logic [MASK_W-1:0] out_victim_fill_mask;
  logic out_status;
  logic out_last;
  logic cfg_wr_en = 1'b0;
  logic [DATA_W-1:0] cfg_wr_data = '0;

  cluster_cache_controller #(
    .SLOTS(NSLOTS),
    .SECTORS_PER_CLUSTER(SPC)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_block_number(in_block_number),
    .in_block_count(in_block_count),
    .in_valid_sectors(in_valid_sectors),
    .out_valid(out_valid),
    .out_slot(out_slot),
    .out_hit(out_hit),
    .out_fill_mask(out_fill_mask),
    .out_writeback(out_writeback),
    .out_victim_cluster(out_victim_cluster),
    .out_victim_sectors(out_victim_sectors),
    .out_victim_fill_mask(out_victim_fill_mask),
    .out_status(out_status),
    .out_last(out_last),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // cache tag state as the block should hold it
  logic [31:0] data_start = '0;
  logic [31:0] cache_cluster[NSLOTS];
  logic [31:0] cache_stamp[NSLOTS];
  logic cache_dirty[NSLOTS];
  logic [MASK_W-1:0] cache_valid[NSLOTS];
  int unsigned cache_used[NSLOTS];
  logic [31:0] stamp_next = '0;

  tag_result_t tag_results[$];
  stim_entry_t pending[$];
  int faults = 0;
  int gap_pct = 0;
  int quiet = 0;
  int cycles = 0;
  logic stim_done = 1'b0;

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      cache_cluster[i] = '0;
      cache_stamp[i] = '0;
      cache_dirty[i] = 1'b0;
      cache_valid[i] = '0;
      cache_used[i] = 0;
    end
  end

  function automatic logic [MASK_W-1:0] sector_run(int unsigned n);
    if (n >= MASK_W) return '1;
    return MASK_W'((9'd1 << n) - 9'd1);
  endfunction

  task automatic resolve_request(logic [1:0] cmd, logic [31:0] blk, logic [3:0] cnt,
                                 logic [3:0] vs);
    tag_result_t r;
    logic [31:0] rel, clus;
    logic [MASK_W-1:0] req, run;
    int unsigned off, fin, sel, dirty_left, lim;
    bit found;
    r = '0;
    if (cmd == CMD_FLUSH) begin
      dirty_left = 0;
      for (int i = 0; i < NSLOTS; i++) dirty_left += cache_dirty[i];
      if (dirty_left == 0) begin
        r.last = 1'b1;
        tag_results.push_back(r);
      end
      for (int i = 0; i < NSLOTS; i++) begin
        if (cache_dirty[i]) begin
          run = sector_run(cache_used[i]);
          r = '0;
          r.slot = SLOT_W'(i);
          r.writeback = 1'b1;
          r.victim_cluster = cache_cluster[i];
          r.victim_sectors = SEC_W'(cache_used[i]);
          r.victim_fill_mask = ~cache_valid[i] & run;
          dirty_left--;
          r.last = (dirty_left == 0);
          tag_results.push_back(r);
          cache_valid[i] |= run;
          cache_dirty[i] = 1'b0;
        end
      end
    end else begin
      rel = blk - data_start;
      off = rel % SPC;
      clus = rel / SPC + 2;
      fin = off + cnt;
      if (cmd == CMD_BAD || blk < data_start || cnt == 0 || fin > SPC || clus == 0) begin
        r.status = 1'b1;
      end else begin
        found = 1'b0;
        sel = 0;
        for (int i = 0; i < NSLOTS; i++) begin
          if (!found && cache_cluster[i] == clus) begin
            sel = i;
            found = 1'b1;
            r.hit = 1'b1;
          end
        end
        for (int i = 0; i < NSLOTS; i++) begin
          if (!found && cache_cluster[i] == 0) begin
            sel = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          for (int i = 1; i < NSLOTS; i++) begin
            if (cache_stamp[i] < cache_stamp[sel]) sel = i;
          end
          if (cache_dirty[sel]) begin
            r.writeback = 1'b1;
            r.victim_cluster = cache_cluster[sel];
            r.victim_sectors = SEC_W'(cache_used[sel]);
            r.victim_fill_mask = ~cache_valid[sel] & sector_run(cache_used[sel]);
          end
        end
        if (!r.hit) begin
          cache_cluster[sel] = clus;
          cache_stamp[sel] = '0;
          cache_dirty[sel] = 1'b0;
          cache_valid[sel] = '0;
          cache_used[sel] = 0;
        end
        req = sector_run(cnt) << off;
        if (cmd == CMD_READ) r.fill_mask = req & ~cache_valid[sel];
        cache_valid[sel] |= req;
        cache_stamp[sel] = stamp_next;
        stamp_next++;
        if (fin > cache_used[sel]) cache_used[sel] = fin;
        if (cmd == CMD_WRITE) begin
          cache_dirty[sel] = 1'b1;
          lim = (vs > SPC) ? SPC : vs;
          if (lim > cache_used[sel]) cache_used[sel] = lim;
        end
        r.slot = SLOT_W'(sel);
      end
      r.last = 1'b1;
      tag_results.push_back(r);
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      faults++;
    end
  endfunction

  function automatic void add_request(logic [1:0] cmd, logic [31:0] blk, logic [3:0] cnt,
                                      logic [3:0] vs);
    stim_entry_t e;
    e.kind = REQ_ENTRY;
    e.cmd = cmd;
    e.blk = blk;
    e.cnt = cnt;
    e.vs = vs;
    e.value = '0;
    pending.push_back(e);
  endfunction

  function automatic void add_control(stim_kind_e kind, logic [31:0] value);
    stim_entry_t e;
    e.kind = kind;
    e.cmd = CMD_READ;
    e.blk = '0;
    e.cnt = '0;
    e.vs = '0;
    e.value = value;
    pending.push_back(e);
  endfunction

  // mostly well-formed requests over a working set of six clusters
  function automatic void add_random_phase(int n, logic [31:0] base);
    longint unsigned room;
    int unsigned k, off, pick;
    logic [1:0] cmd;
    logic [31:0] blk;
    logic [3:0] cnt, vs;
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(99, 0);
      room = 64'hFFFF_FFFF - base;
      k = (room / SPC > 5) ? 5 : int'(room / SPC);
      k = $urandom_range(k, 0);
      room = room - k * SPC;
      off = $urandom_range((room > SPC - 1) ? SPC - 1 : int'(room), 0);
      blk = base + k * SPC + off;
      cmd = $urandom_range(1, 0) ? CMD_WRITE : CMD_READ;
      cnt = 4'($urandom_range(SPC - off, 1));
      vs = ($urandom_range(9, 0) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(SPC, 0));
      if (pick < 7) begin
        cmd = CMD_FLUSH;
      end else if (pick < 80) begin
      end else if (pick < 87) begin
        cnt = (pick == 80) ? 4'd0 : 4'($urandom_range(15, SPC + 1 - off));
      end else if (pick < 94) begin
        cmd = 2'($urandom_range(3, 0));
        blk = $urandom;
        cnt = 4'($urandom_range(15, 0));
      end else if (base != 0) begin
        blk = $urandom_range(base - 1, 0);
      end else begin
        cmd = CMD_BAD;
      end
      add_request(cmd, blk, cnt, vs);
    end
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    stim_entry_t e;
    logic nxt_start, nxt_cfg;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_wr_en <= 1'b0;
      quiet = 0;
    end else begin
      nxt_start = start && busy;
      nxt_cfg = 1'b0;
      quiet = (busy || out_valid || start) ? 0 : quiet + 1;
      if (!nxt_start && pending.size() != 0) begin
        e = pending[0];
        case (e.kind)
          REQ_ENTRY: begin
            if ($urandom_range(99, 0) >= gap_pct) begin
              nxt_start = 1'b1;
              in_command <= e.cmd;
              in_block_number <= e.blk;
              in_block_count <= e.cnt;
              in_valid_sectors <= e.vs;
              void'(pending.pop_front());
            end
          end
          SET_GAP: begin
            gap_pct = e.value;
            void'(pending.pop_front());
          end
          default: begin
            if (tag_results.size() == 0 && quiet >= SETTLE) begin
              if (e.kind == SET_BASE) begin
                nxt_cfg = 1'b1;
                cfg_wr_data <= e.value;
              end
              void'(pending.pop_front());
            end
          end
        endcase
      end
      start <= nxt_start;
      cfg_wr_en <= nxt_cfg;
      stim_done <= (pending.size() == 0) && !nxt_start;
    end
  end

  // monitor
  always @(posedge clk) begin
    tag_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (tag_results.size() == 0) begin
          $error("result with no request outstanding: slot %0d", out_slot);
          faults++;
        end else begin
          want = tag_results.pop_front();
          check_field("slot", want.slot, out_slot);
          check_field("hit", want.hit, out_hit);
          check_field("fill_mask", want.fill_mask, out_fill_mask);
          check_field("writeback", want.writeback, out_writeback);
          check_field("victim_cluster", want.victim_cluster, out_victim_cluster);
          check_field("victim_sectors", want.victim_sectors, out_victim_sectors);
          check_field("victim_fill_mask", want.victim_fill_mask, out_victim_fill_mask);
          check_field("status", want.status, out_status);
          check_field("last", want.last, out_last);
        end
      end
      if (cfg_wr_en) data_start = cfg_wr_data;
      if (start && !busy) begin
        resolve_request(in_command, in_block_number, in_block_count, in_valid_sectors);
      end
    end
  end

  initial begin
    add_control(SET_GAP, 0);
    add_control(SET_BASE, 32'h0);
    add_request(CMD_FLUSH, 32'h0, 4'd1, 4'd0);
    add_request(CMD_READ, 32'd0, 4'd8, 4'd0);
    add_request(CMD_READ, 32'd0, 4'd1, 4'd0);
    add_request(CMD_WRITE, 32'd11, 4'd5, 4'd2);
    add_request(CMD_WRITE, 32'd16, 4'd1, 4'd8);
    add_request(CMD_WRITE, 32'd31, 4'd1, 4'd15);
    add_request(CMD_READ, 32'd32, 4'd2, 4'd0);
    add_request(CMD_READ, 32'd40, 4'd8, 4'd0);
    add_request(CMD_WRITE, 32'd48, 4'd3, 4'd0);
    add_request(CMD_FLUSH, 32'hFFFF_FFFF, 4'd15, 4'd15);
    add_request(CMD_FLUSH, 32'h0, 4'd0, 4'd0);
    add_request(CMD_READ, 32'hFFFF_FFFF, 4'd1, 4'd0);
    add_request(CMD_WRITE, 32'hFFFF_FFF8, 4'd8, 4'd4);
    add_request(CMD_WRITE, 32'h7FFF_FFFF, 4'd1, 4'd9);
    add_request(CMD_WRITE, 32'd0, 4'd4, 4'd3);
    add_request(CMD_WRITE, 32'd64, 4'd2, 4'd0);
    add_request(CMD_FLUSH, 32'h0, 4'd1, 4'd0);
    add_request(CMD_READ, 32'd8, 4'd0, 4'd0);
    add_request(CMD_READ, 32'd5, 4'd4, 4'd0);
    add_request(CMD_BAD, 32'd0, 4'd1, 4'd0);
    add_request(CMD_WRITE, 32'd0, 4'd15, 4'd0);
    add_control(WAIT_QUIET, 0);
    add_control(SET_BASE, 32'h1000);
    add_request(CMD_READ, 32'h0FFF, 4'd1, 4'd0);
    add_request(CMD_READ, 32'h0, 4'd1, 4'd0);
    add_request(CMD_WRITE, 32'h1000, 4'd8, 4'd8);
    add_random_phase(40, 32'h1000);
    add_control(WAIT_QUIET, 0);
    add_random_phase(40, 32'h1000);
    add_control(WAIT_QUIET, 0);
    add_control(SET_BASE, 32'hFFFF_FFF0);
    add_control(SET_GAP, 45);
    add_random_phase(60, 32'hFFFF_FFF0);
    begin
      logic [31:0] mid_base;
      mid_base = $urandom;
      add_control(WAIT_QUIET, 0);
      add_control(SET_BASE, mid_base);
      add_control(SET_GAP, 18);
      add_random_phase(90, mid_base);
    end
    add_control(WAIT_QUIET, 0);
    add_control(SET_BASE, 32'hFFFF_FFFF);
    add_control(SET_GAP, 45);
    add_random_phase(30, 32'hFFFF_FFFF);
    add_control(WAIT_QUIET, 0);
    add_control(SET_BASE, 32'h0);
    add_control(SET_GAP, 0);
    add_random_phase(50, 32'h0);
    add_control(SET_GAP, 45);
    add_random_phase(60, 32'h0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!(stim_done && tag_results.size() == 0 && !busy));
    repeat (24) @(posedge clk);
    if (faults == 0 && tag_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
